>>> sv/iee_pkg.sv
// Shared types, constants and helper functions of the infix expression evaluator.
`default_nettype none

package iee_pkg;

    localparam int VALUE_BITS          = 48;
    localparam int FRACTION_BITS_DFLT  = 16;
    localparam int NUMBER_BITS_DFLT    = 32;
    localparam int CMD_DEPTH_DFLT      = 4;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_END
    } t_back_state;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         overflowed;
        logic                         divided_by_zero;
    } t_out_item;

    typedef struct packed {
        logic has_num;
        t_op  op;
        logic is_end;
        logic sat;
    } t_cmd_ctl;

    // Returns the overflow flag above the clamped 48-bit sum.
    function automatic logic [VALUE_BITS:0] sat_add(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS:0] s;
        logic [VALUE_BITS:0] r;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            r = {1'b1, (s[VALUE_BITS] ? VALUE_MIN : VALUE_MAX)};
        end else begin
            r = {1'b0, s[VALUE_BITS-1:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/infix_expression_evaluator_top.sv
// Top level of the infix expression evaluator: front end, command queue and back end.
//
// Channel   Direction  Handshake                   Payload
// input     in         push / full  (push & !full) i_data : t_in_item
// result    out        pop / empty  (pop & !empty) o_data : t_out_item
//
// A character or end item is taken while the command queue has room.
// Each command is issued from the idle state; a multiply then runs a shift-and-add loop
// and a nonzero divide a shift-and-subtract loop; an end item passes through the end state.
// Reset is synchronous and clears the number builder, queue, term, sum and flags.
// The queue fills while the back end is busy, and full then holds off new input.
// A held result stalls only the back end; input is still taken until the queue fills.
`default_nettype none

module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DFLT,
    parameter int NUMBER_BITS   = NUMBER_BITS_DFLT,
    parameter int CMD_DEPTH     = CMD_DEPTH_DFLT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_data,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_data
);

    localparam int CMD_W = $bits(t_cmd_ctl) + NUMBER_BITS;

    logic                   cmd_push;
    t_cmd_ctl               cmd_ctl_in;
    logic [NUMBER_BITS-1:0] cmd_num_in;
    logic                   cmd_full;
    logic                   cmd_pop;
    logic                   cmd_empty;
    logic [CMD_W-1:0]       cmd_head;
    t_cmd_ctl               cmd_ctl_out;
    logic [NUMBER_BITS-1:0] cmd_num_out;

    assign full        = cmd_full;
    assign cmd_ctl_out = t_cmd_ctl'(cmd_head[CMD_W-1:NUMBER_BITS]);
    assign cmd_num_out = cmd_head[NUMBER_BITS-1:0];

    iee_front #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd_ctl  (cmd_ctl_in),
        .o_cmd_num  (cmd_num_in)
    );

    iee_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({cmd_ctl_in, cmd_num_in}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    iee_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .NUMBER_BITS   (NUMBER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_ctl   (cmd_ctl_out),
        .i_cmd_num   (cmd_num_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

>>> sv/iee_front.sv
// Front end: accepts characters, builds the decimal number and issues commands.
`default_nettype none

module iee_front
    import iee_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DFLT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire t_in_item               i_data,
    input  wire logic                   i_cmd_full,
    output logic                        o_cmd_push,
    output t_cmd_ctl                    o_cmd_ctl,
    output logic [NUMBER_BITS-1:0]      o_cmd_num
);

    logic [NUMBER_BITS-1:0] r_pend, n_pend;
    logic                   r_digits, n_digits;
    t_op                    r_op, n_op;
    logic                   r_dsat, n_dsat;

    logic                   accept;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [7:0]             digit_wide;
    logic [NUMBER_BITS+3:0] times_ten;
    logic                   digit_ovf;

    assign accept     = i_push && !i_cmd_full;
    assign is_digit   = (i_data.char_code inside {[CH_ZERO:CH_NINE]});
    assign digit_wide = i_data.char_code - CH_ZERO;
    assign digit      = digit_wide[3:0];
    assign times_ten  = ({4'b0, r_pend} << 3) + ({4'b0, r_pend} << 1)
                        + {{NUMBER_BITS{1'b0}}, digit};
    assign digit_ovf  = |times_ten[NUMBER_BITS+3:NUMBER_BITS];

    always_comb begin
        n_pend     = r_pend;
        n_digits   = r_digits;
        n_op       = r_op;
        n_dsat     = r_dsat;
        o_cmd_push = 1'b0;
        o_cmd_ctl  = '{has_num: r_digits, op: r_op, is_end: 1'b0, sat: r_dsat};
        o_cmd_num  = r_pend;
        if (accept) begin
            if (i_data.end_of_text) begin
                o_cmd_push       = 1'b1;
                o_cmd_ctl.is_end = 1'b1;
                n_pend           = '0;
                n_digits         = 1'b0;
                n_op             = OP_PLUS;
                n_dsat           = 1'b0;
            end else if (is_digit) begin
                n_digits = 1'b1;
                if (digit_ovf) begin
                    n_pend = '1;
                    n_dsat = 1'b1;
                end else begin
                    n_pend = times_ten[NUMBER_BITS-1:0];
                end
            end else begin
                if (r_digits) begin
                    o_cmd_push = 1'b1;
                    n_dsat     = 1'b0;
                end
                n_pend   = '0;
                n_digits = 1'b0;
                case (i_data.char_code)
                    CH_PLUS:   n_op = OP_PLUS;
                    CH_MINUS:  n_op = OP_MINUS;
                    CH_TIMES:  n_op = OP_TIMES;
                    CH_DIVIDE: n_op = OP_DIVIDE;
                    default:   n_op = r_op;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_digits <= 1'b0;
            r_op     <= OP_PLUS;
            r_dsat   <= 1'b0;
        end else begin
            r_pend   <= n_pend;
            r_digits <= n_digits;
            r_op     <= n_op;
            r_dsat   <= n_dsat;
        end
    end

endmodule

`default_nettype wire

>>> sv/iee_cmd_fifo.sv
// Small register queue that carries commands from the front end to the back end.
`default_nettype none

module iee_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/iee_back.sv
// Back end: applies numbers to the term and sum, with iterative multiply and divide.
`default_nettype none

module iee_back
    import iee_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DFLT,
    parameter int NUMBER_BITS   = NUMBER_BITS_DFLT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_empty,
    input  wire t_cmd_ctl               i_cmd_ctl,
    input  wire logic [NUMBER_BITS-1:0] i_cmd_num,
    output logic                        o_cmd_pop,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output t_out_item                   o_data
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int ACC_W = VALUE_BITS + 2;
    localparam logic [VALUE_BITS-1:0] FIX_LIMIT = VALUE_MAX >> FRACTION_BITS;
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(NUMBER_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(VALUE_BITS - 1);

    t_back_state r_state, n_state;

    logic [VALUE_BITS-1:0]  r_sum, n_sum;
    logic [VALUE_BITS-1:0]  r_term, n_term;
    logic                   r_sat, n_sat;
    logic                   r_zdiv, n_zdiv;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic                   r_neg, n_neg;
    logic [VALUE_BITS-1:0]  r_mag, n_mag;
    logic [NUMBER_BITS-1:0] r_num, n_num;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic                   r_movf, n_movf;
    logic [VALUE_BITS-1:0]  r_quo, n_quo;
    logic [NUMBER_BITS-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_end, n_end;

    logic                   head_valid;
    logic [VALUE_BITS:0]    add_res;
    logic [VALUE_BITS-1:0]  num_wide;
    logic                   fix_ovf;
    logic [VALUE_BITS-1:0]  fix_val;
    logic                   term_neg;
    logic [VALUE_BITS-1:0]  term_mag;
    logic [VALUE_BITS-1:0]  mul_limit;
    logic [ACC_W-1:0]       mul_next;
    logic                   mul_over;
    logic [NUMBER_BITS:0]   div_shift;
    logic                   div_ge;
    logic [NUMBER_BITS:0]   div_diff;
    logic [VALUE_BITS-1:0]  quo_next;
    logic                   last_step;

    assign head_valid = !i_cmd_empty;
    assign add_res    = sat_add(r_sum, r_term);
    assign num_wide   = {{(VALUE_BITS-NUMBER_BITS){1'b0}}, i_cmd_num};
    assign fix_ovf    = (num_wide > FIX_LIMIT);
    assign fix_val    = fix_ovf ? VALUE_MAX : VALUE_BITS'(num_wide << FRACTION_BITS);
    assign term_neg   = r_term[VALUE_BITS-1];
    assign term_mag   = term_neg ? (~r_term + 1'b1) : r_term;
    assign last_step  = (r_cnt == '0);

    assign mul_limit  = r_neg ? VALUE_MIN : VALUE_MAX;
    assign mul_next   = {r_acc[ACC_W-2:0], 1'b0}
                        + (r_num[NUMBER_BITS-1] ? {2'b00, r_mag} : '0);
    assign mul_over   = r_movf || (mul_next > {2'b00, mul_limit});

    assign div_shift  = {r_rem, r_mag[VALUE_BITS-1]};
    assign div_ge     = (div_shift >= {1'b0, r_num});
    assign div_diff   = div_shift - {1'b0, r_num};
    assign quo_next   = {r_quo[VALUE_BITS-2:0], div_ge};

    assign o_empty    = !r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (head_valid) begin
                    if (i_cmd_ctl.has_num && i_cmd_ctl.op == OP_TIMES) begin
                        n_state = ST_MUL;
                    end else if (i_cmd_ctl.has_num && i_cmd_ctl.op == OP_DIVIDE
                                 && i_cmd_num != '0) begin
                        n_state = ST_DIV;
                    end else if (i_cmd_ctl.is_end) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_MUL, ST_DIV: begin
                if (last_step) begin
                    n_state = r_end ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sum       = r_sum;
        n_term      = r_term;
        n_sat       = r_sat;
        n_zdiv      = r_zdiv;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_num       = r_num;
        n_acc       = r_acc;
        n_movf      = r_movf;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_end       = r_end;
        o_cmd_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (head_valid) begin
                    o_cmd_pop = 1'b1;
                    n_end     = i_cmd_ctl.is_end;
                    n_sat     = r_sat || i_cmd_ctl.sat;
                    n_neg     = term_neg;
                    n_mag     = term_mag;
                    n_num     = i_cmd_num;
                    n_acc     = '0;
                    n_movf    = 1'b0;
                    n_quo     = '0;
                    n_rem     = '0;
                    if (i_cmd_ctl.has_num) begin
                        case (i_cmd_ctl.op)
                            OP_PLUS, OP_MINUS: begin
                                n_sum  = add_res[VALUE_BITS-1:0];
                                n_term = (i_cmd_ctl.op == OP_MINUS) ? (~fix_val + 1'b1)
                                                                    : fix_val;
                                n_sat  = r_sat || i_cmd_ctl.sat || add_res[VALUE_BITS]
                                         || fix_ovf;
                            end
                            OP_TIMES: begin
                                n_cnt = MUL_STEPS;
                            end
                            OP_DIVIDE: begin
                                n_cnt = DIV_STEPS;
                                if (i_cmd_num == '0) begin
                                    n_term = '0;
                                    n_zdiv = 1'b1;
                                end
                            end
                            default: n_term = r_term;
                        endcase
                    end
                end
            end
            ST_MUL: begin
                n_num  = r_num << 1;
                n_cnt  = r_cnt - 1'b1;
                n_movf = mul_over;
                if (!mul_over) begin
                    n_acc = mul_next;
                end
                if (last_step) begin
                    if (mul_over) begin
                        n_term = r_neg ? VALUE_MIN : VALUE_MAX;
                        n_sat  = 1'b1;
                    end else begin
                        n_term = r_neg ? (~mul_next[VALUE_BITS-1:0] + 1'b1)
                                       : mul_next[VALUE_BITS-1:0];
                    end
                end
            end
            ST_DIV: begin
                n_mag = r_mag << 1;
                n_cnt = r_cnt - 1'b1;
                n_quo = quo_next;
                n_rem = div_ge ? div_diff[NUMBER_BITS-1:0] : div_shift[NUMBER_BITS-1:0];
                if (last_step) begin
                    n_term = r_neg ? (~quo_next + 1'b1) : quo_next;
                end
            end
            ST_END: begin
                if (!r_out_valid) begin
                    n_out_valid           = 1'b1;
                    n_out.value           = add_res[VALUE_BITS-1:0];
                    n_out.overflowed      = r_sat || add_res[VALUE_BITS];
                    n_out.divided_by_zero = r_zdiv;
                    n_sum                 = '0;
                    n_term                = '0;
                    n_sat                 = 1'b0;
                    n_zdiv                = 1'b0;
                end
            end
            default: n_sum = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_term      <= '0;
            r_sat       <= 1'b0;
            r_zdiv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_sat       <= n_sat;
            r_zdiv      <= n_zdiv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_num  <= n_num;
        r_acc  <= n_acc;
        r_movf <= n_movf;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_end  <= n_end;
    end

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> head_valid)
        else $error("command popped from an empty queue");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_pop)
        else $error("command popped while a command is still in progress");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_num != '0))
        else $error("iterative divide started with a zero divisor");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && !r_out_valid) |=>
            (r_state == ST_IDLE && r_out_valid && r_sum == '0 && r_term == '0
             && !r_sat && !r_zdiv))
        else $error("result load did not clear the expression state");

endmodule

`default_nettype wire
